[rtl/core/grs_pkg.sv]
// ----------------------------------------------------------------------------
// grs_pkg: shared types and constants for the gaze region statistics block
// Holds the region table size, field widths, mode codes and the probe beat
// that travels along the chain of region cells.
// ----------------------------------------------------------------------------
package grs_pkg;

    localparam int MAX_REGIONS = 32;
    localparam int REGION_BITS = 5;
    localparam int COUNT_BITS  = 6;
    localparam int COORD_BITS  = 12;
    localparam int LABEL_BITS  = 8;
    localparam int DUR_BITS    = 16;
    localparam int FIX_BITS    = 24;
    localparam int DWELL_BITS  = 32;

    localparam logic [FIX_BITS-1:0]   FIX_MAX   = '1;
    localparam logic [DWELL_BITS-1:0] DWELL_MAX = '1;

    // APB register index
    localparam logic REG_REGION_COUNT = 1'b0;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_GAZE = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef struct packed {
        logic                   valid;
        logic [1:0]             mode;
        logic [REGION_BITS-1:0] slot;
        logic [COORD_BITS-1:0]  x_pos;
        logic [COORD_BITS-1:0]  y_pos;
        logic [COORD_BITS-1:0]  span_x;
        logic [COORD_BITS-1:0]  span_y;
        logic [LABEL_BITS-1:0]  label;
        logic [DUR_BITS-1:0]    duration;
        logic                   found;
        logic [REGION_BITS-1:0] region;
        logic [LABEL_BITS-1:0]  region_label;
        logic [FIX_BITS-1:0]    fix_total;
        logic [DWELL_BITS-1:0]  dwell_total;
    } probe_t;

endpackage

[rtl/core/grs_in_if.sv]
// ----------------------------------------------------------------------------
// grs_in_if: input item channel
// Valid/ready channel carrying one load, gaze or read item per beat.
// ----------------------------------------------------------------------------
interface grs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [4:0]  slot;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic [11:0] span_x;
    logic [11:0] span_y;
    logic [7:0]  label;
    logic [15:0] duration;

    modport source (output valid, mode, slot, x_pos, y_pos, span_x, span_y, label, duration,
                    input ready);
    modport sink (input valid, mode, slot, x_pos, y_pos, span_x, span_y, label, duration,
                  output ready);
endinterface

[rtl/core/grs_out_if.sv]
// ----------------------------------------------------------------------------
// grs_out_if: result channel
// Valid/ready channel carrying one region result per beat.
// ----------------------------------------------------------------------------
interface grs_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [4:0]  region;
    logic [7:0]  region_label;
    logic [23:0] fix_total;
    logic [31:0] dwell_total;

    modport source (output valid, hit, region, region_label, fix_total, dwell_total,
                    input ready);
    modport sink (input valid, hit, region, region_label, fix_total, dwell_total,
                  output ready);
endinterface

[rtl/core/gaze_region_statistics.sv]
// ----------------------------------------------------------------------------
// gaze_region_statistics: region of interest hit counter for gaze samples
// Keeps up to 32 rectangular regions, each with a label, a fixation count
// and a saturating dwell-time sum, held in a chain of region cells.
//
// Usage:
//   gaze_in   valid/ready channel; one beat is a load, gaze or read item.
//   stat_out  valid/ready channel; exactly one result beat per input beat.
//   APB port  register 0 (address 0) is region_count, the number of
//             slots in use; write it only while the block is idle.
// Timing: an accepted beat walks the 32 cells one cell per cycle while the
//   chain is not frozen, and its result is then registered for stat_out.
//   One item is in flight in the chain at a time; the next beat is taken
//   once the result is registered, so the chain length sets the item rate.
// Stall: the result register holds while stat_out is not ready, and a new
//   item may still enter; its beat freezes at the chain end until the
//   output register frees.
// Reset: counters, region_count and all handshake state clear; region
//   geometry and labels stay undefined until loaded.
// ----------------------------------------------------------------------------
module gaze_region_statistics (
    input  logic        clk,
    input  logic        rst_n,
    grs_in_if.sink      gaze_in,
    grs_out_if.source   stat_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import grs_pkg::*;

    probe_t                chain [0:MAX_REGIONS];
    probe_t                res_reg;
    logic                  res_valid_reg;
    logic                  busy_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] in_use;
    logic                  advance;
    logic                  accept;
    logic                  retire;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_REGION_COUNT);
    assign prdata    = (paddr[2] == REG_REGION_COUNT) ? {{(32-COUNT_BITS){1'b0}}, count_reg} : '0;
    assign in_use    = (count_reg > COUNT_BITS'(MAX_REGIONS)) ? COUNT_BITS'(MAX_REGIONS)
                                                             : count_reg;

    assign gaze_in.ready = !busy_reg;
    assign accept        = gaze_in.valid && !busy_reg;
    // freeze the chain while a finished beat has nowhere to go
    assign advance       = !(chain[MAX_REGIONS].valid && res_valid_reg && !stat_out.ready);
    assign retire        = chain[MAX_REGIONS].valid && advance;

    always_comb
    begin
        chain[0]          = '0;
        chain[0].valid    = accept;
        chain[0].mode     = gaze_in.mode;
        chain[0].slot     = gaze_in.slot;
        chain[0].x_pos    = gaze_in.x_pos;
        chain[0].y_pos    = gaze_in.y_pos;
        chain[0].span_x   = gaze_in.span_x;
        chain[0].span_y   = gaze_in.span_y;
        chain[0].label    = gaze_in.label;
        chain[0].duration = gaze_in.duration;
    end

    for (genvar i = 0; i < MAX_REGIONS; i++)
    begin : g_cell
        grs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .cell_index (REGION_BITS'(i)),
            .in_use     (in_use),
            .probe_in   (chain[i]),
            .probe_out  (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                count_reg <= pwdata[COUNT_BITS-1:0];
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (retire)
            begin
                busy_reg <= 1'b0;
            end
            if (retire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (stat_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            res_reg <= chain[MAX_REGIONS];
        end
    end

    assign stat_out.valid        = res_valid_reg;
    assign stat_out.hit          = res_reg.found;
    assign stat_out.region       = res_reg.region;
    assign stat_out.region_label = res_reg.region_label;
    assign stat_out.fix_total    = res_reg.fix_total;
    assign stat_out.dwell_total  = res_reg.dwell_total;

`ifndef SYNTH
    a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !chain[MAX_REGIONS].valid)
        else $error("beat at chain end while block idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not set after accept");

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> res_valid_reg && busy_reg)
        else $error("chain frozen without a pending result");

    a_retire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        retire |=> res_valid_reg && !busy_reg)
        else $error("retired beat did not reach the output register");
`endif

endmodule

[rtl/core/grs_cell.sv]
// ----------------------------------------------------------------------------
// grs_cell: one region slot of the table
// Holds one region's geometry, label and counters, and acts on the probe
// beat that passes through it before handing the beat to the next cell.
// ----------------------------------------------------------------------------
module grs_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [grs_pkg::REGION_BITS-1:0] cell_index,
    input  logic [grs_pkg::COUNT_BITS-1:0]  in_use,
    input  grs_pkg::probe_t               probe_in,
    output grs_pkg::probe_t               probe_out
);
    import grs_pkg::*;

    logic [COORD_BITS-1:0] left_reg, left_next;
    logic [COORD_BITS-1:0] top_reg, top_next;
    logic [COORD_BITS-1:0] width_reg, width_next;
    logic [COORD_BITS-1:0] height_reg, height_next;
    logic [LABEL_BITS-1:0] label_reg, label_next;
    logic [FIX_BITS-1:0]   fix_reg, fix_next;
    logic [DWELL_BITS-1:0] dwell_reg, dwell_next;
    probe_t                probe_reg, probe_next;

    logic                  slot_live;
    logic                  slot_match;
    logic                  contains;
    logic [COORD_BITS:0]   right_edge;
    logic [COORD_BITS:0]   bottom_edge;
    logic [DWELL_BITS:0]   dwell_sum;
    logic [FIX_BITS-1:0]   fix_inc;
    logic [DWELL_BITS-1:0] dwell_inc;

    assign slot_live   = {1'b0, cell_index} < in_use;
    assign slot_match  = probe_in.slot == cell_index;
    assign right_edge  = {1'b0, left_reg} + {1'b0, width_reg};
    assign bottom_edge = {1'b0, top_reg} + {1'b0, height_reg};
    assign contains    = (probe_in.x_pos >= left_reg) && ({1'b0, probe_in.x_pos} <= right_edge)
                      && (probe_in.y_pos >= top_reg) && ({1'b0, probe_in.y_pos} <= bottom_edge);
    assign dwell_sum   = {1'b0, dwell_reg} + {{(DWELL_BITS-DUR_BITS+1){1'b0}}, probe_in.duration};
    assign fix_inc     = (fix_reg == FIX_MAX) ? fix_reg : fix_reg + 1'b1;
    assign dwell_inc   = dwell_sum[DWELL_BITS] ? DWELL_MAX : dwell_sum[DWELL_BITS-1:0];

    always_comb
    begin
        left_next   = left_reg;
        top_next    = top_reg;
        width_next  = width_reg;
        height_next = height_reg;
        label_next  = label_reg;
        fix_next    = fix_reg;
        dwell_next  = dwell_reg;
        probe_next  = probe_in;
        if (probe_in.valid)
        begin
            unique case (mode_t'(probe_in.mode))
                MODE_LOAD:
                begin
                    if (slot_match)
                    begin
                        left_next   = probe_in.x_pos;
                        top_next    = probe_in.y_pos;
                        width_next  = probe_in.span_x;
                        height_next = probe_in.span_y;
                        label_next  = probe_in.label;
                        fix_next    = '0;
                        dwell_next  = '0;
                        probe_next.found        = 1'b1;
                        probe_next.region       = cell_index;
                        probe_next.region_label = probe_in.label;
                        probe_next.fix_total    = '0;
                        probe_next.dwell_total  = '0;
                    end
                end
                MODE_GAZE:
                begin
                    // first live region that contains the point takes the sample
                    if (!probe_in.found && slot_live && contains)
                    begin
                        fix_next   = fix_inc;
                        dwell_next = dwell_inc;
                        probe_next.found        = 1'b1;
                        probe_next.region       = cell_index;
                        probe_next.region_label = label_reg;
                        probe_next.fix_total    = fix_inc;
                        probe_next.dwell_total  = dwell_inc;
                    end
                end
                MODE_READ:
                begin
                    if (slot_match && slot_live)
                    begin
                        probe_next.found        = 1'b1;
                        probe_next.region       = cell_index;
                        probe_next.region_label = label_reg;
                        probe_next.fix_total    = fix_reg;
                        probe_next.dwell_total  = dwell_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_reg   <= '0;
            dwell_reg <= '0;
            probe_reg <= '0;
        end
        else if (advance)
        begin
            fix_reg   <= fix_next;
            dwell_reg <= dwell_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            label_reg  <= label_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

[test/gaze_region_statistics_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaze_region_statistics_tb: self-checking bench for the gaze region block
// Drives load, gaze, read and none-mode items under random idling on both channels,
// sweeps region_count over the APB port, and checks every result beat
// against an in-bench model of the region table.
// ----------------------------------------------------------------------------
module gaze_region_statistics_tb;
    import grs_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [4:0]  region;
        logic [7:0]  region_label;
        logic [23:0] fix_total;
        logic [31:0] dwell_total;
    } region_stat_t;

    class region_scoreboard;
        logic [11:0] left_q [MAX_REGIONS];
        logic [11:0] top_q [MAX_REGIONS];
        logic [11:0] wid_q [MAX_REGIONS];
        logic [11:0] hgt_q [MAX_REGIONS];
        logic [7:0]  lab_q [MAX_REGIONS];
        logic [23:0] fix_q [MAX_REGIONS];
        logic [31:0] dwell_q [MAX_REGIONS];
        logic [5:0]  count;
        region_stat_t pending [$];
        int errors;
        int checked;

        function new();
            count = 0;
            errors = 0;
            checked = 0;
            for (int i = 0; i < MAX_REGIONS; i++)
            begin
                fix_q[i] = 0;
                dwell_q[i] = 0;
                left_q[i] = 0; top_q[i] = 0; wid_q[i] = 0; hgt_q[i] = 0; lab_q[i] = 0;
            end
        endfunction

        function region_stat_t slot_stat(int s);
            region_stat_t r;
            r.hit = 1'b1;
            r.region = s[4:0];
            r.region_label = lab_q[s];
            r.fix_total = fix_q[s];
            r.dwell_total = dwell_q[s];
            return r;
        endfunction

        function void note_item(logic [1:0] mode, logic [4:0] slot, logic [11:0] x,
                                logic [11:0] y, logic [11:0] sx, logic [11:0] sy,
                                logic [7:0] lab, logic [15:0] dur);
            region_stat_t r;
            int used;
            logic [32:0] dsum;
            r = '0;
            used = (count > MAX_REGIONS) ? MAX_REGIONS : count;
            case (mode)
                MODE_LOAD:
                begin
                    left_q[slot] = x; top_q[slot] = y; wid_q[slot] = sx; hgt_q[slot] = sy;
                    lab_q[slot] = lab;
                    fix_q[slot] = 0;
                    dwell_q[slot] = 0;
                    r = slot_stat(slot);
                end
                MODE_GAZE:
                begin
                    for (int i = 0; i < used; i++)
                    begin
                        if (x >= left_q[i] && {1'b0, x} <= {1'b0, left_q[i]} + wid_q[i] &&
                            y >= top_q[i] && {1'b0, y} <= {1'b0, top_q[i]} + hgt_q[i])
                        begin
                            if (fix_q[i] != FIX_MAX)
                                fix_q[i] = fix_q[i] + 24'd1;
                            dsum = {1'b0, dwell_q[i]} + dur;
                            dwell_q[i] = dsum[32] ? DWELL_MAX : dsum[31:0];
                            r = slot_stat(i);
                            break;
                        end
                    end
                end
                MODE_READ:
                    if (slot < used)
                        r = slot_stat(slot);
                default: r = '0;
            endcase
            pending.push_back(r);
        endfunction

        function void check_stat(region_stat_t got);
            region_stat_t want;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit || got.region !== want.region ||
                got.region_label !== want.region_label ||
                got.fix_total !== want.fix_total || got.dwell_total !== want.dwell_total)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected hit=%0d reg=%0d lab=%h fix=%0d dwell=%0d,",
                             want.hit, want.region, want.region_label, want.fix_total,
                             want.dwell_total,
                             " got hit=%0d reg=%0d lab=%h fix=%0d dwell=%0d",
                             got.hit, got.region, got.region_label,
                             got.fix_total, got.dwell_total);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    grs_in_if  gaze_ch();
    grs_out_if stat_ch();

    gaze_region_statistics dut (
        .clk(clk), .rst_n(rst_n), .gaze_in(gaze_ch.sink), .stat_out(stat_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    region_scoreboard board;
    int idle_cycles;
    int hold_off;
    int gaze_beats;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        gaze_ch.valid = 0; gaze_ch.mode = 0; gaze_ch.slot = 0; gaze_ch.x_pos = 0;
        gaze_ch.y_pos = 0; gaze_ch.span_x = 0; gaze_ch.span_y = 0; gaze_ch.label = 0;
        gaze_ch.duration = 0;
        stat_ch.ready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    end

    // accepted beats of both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (gaze_ch.valid && gaze_ch.ready)
            begin
                board.note_item(gaze_ch.mode, gaze_ch.slot, gaze_ch.x_pos, gaze_ch.y_pos,
                                gaze_ch.span_x, gaze_ch.span_y, gaze_ch.label,
                                gaze_ch.duration);
                gaze_beats++;
            end
            if (stat_ch.valid && stat_ch.ready)
                board.check_stat({stat_ch.hit, stat_ch.region, stat_ch.region_label,
                                  stat_ch.fix_total, stat_ch.dwell_total});
            if ((gaze_ch.valid && gaze_ch.ready) || (stat_ch.valid && stat_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_cycles > 20000)
            begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("gaze_region_statistics_tb failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off
    initial
    begin
        int w;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                stat_ch.ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (w > 0)
            begin
                stat_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            stat_ch.ready <= 1'b1;
            do @(posedge clk); while (!stat_ch.valid);
            stat_ch.ready <= 1'b0;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0)
            board.count = data[5:0];
    endtask

    // drop valid after the last beat, then wait for every result
    task automatic drain();
        gaze_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // valid stays high into the next item when it follows with no gap
    task automatic send_item(input logic [1:0] mode, input logic [4:0] slot,
                             input logic [11:0] x, input logic [11:0] y,
                             input logic [11:0] sx, input logic [11:0] sy,
                             input logic [7:0] lab, input logic [15:0] dur,
                             input bit no_gap);
        int w;
        w = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
        if (w > 0)
        begin
            gaze_ch.valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        gaze_ch.valid <= 1'b1;
        gaze_ch.mode <= mode; gaze_ch.slot <= slot; gaze_ch.x_pos <= x; gaze_ch.y_pos <= y;
        gaze_ch.span_x <= sx; gaze_ch.span_y <= sy; gaze_ch.label <= lab;
        gaze_ch.duration <= dur;
        do @(posedge clk); while (!gaze_ch.ready);
    endtask

    task automatic load_all(input bit small_boxes);
        for (int s = 0; s < MAX_REGIONS; s++)
            send_item(MODE_LOAD, 5'(s), 12'($urandom), 12'($urandom),
                      small_boxes ? 12'($urandom_range(0, 600)) : 12'($urandom),
                      small_boxes ? 12'($urandom_range(0, 600)) : 12'($urandom),
                      8'($urandom), 16'($urandom), 0);
    endtask

    task automatic random_item();
        int pick;
        logic [4:0] s;
        pick = $urandom_range(0, 9);
        s = 5'($urandom);
        if (pick == 0)
            send_item(MODE_LOAD, s, 12'($urandom), 12'($urandom),
                      12'($urandom_range(0, 1500)), 12'($urandom_range(0, 1500)),
                      8'($urandom), 16'($urandom), 0);
        else if (pick <= 6)
            send_item(MODE_GAZE, s, 12'($urandom), 12'($urandom), 12'($urandom),
                      12'($urandom), 8'($urandom),
                      ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom), 0);
        else if (pick <= 8)
            send_item(MODE_READ, s, 12'($urandom), 12'($urandom), 12'($urandom),
                      12'($urandom), 8'($urandom), 16'($urandom), 0);
        else
            send_item(MODE_NONE, s, 12'($urandom), 12'($urandom), 12'($urandom),
                      12'($urandom), 8'($urandom), 16'($urandom), 0);
    endtask

    initial
    begin
        logic [5:0] settings [5];
        board = new();
        idle_cycles = 0;
        hold_off = 0;
        gaze_beats = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, then edges and extremes
        send_item(MODE_GAZE, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(MODE_NONE, 5'h1F, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 16'hFFFF, 0);
        send_item(MODE_LOAD, 0, 100, 200, 10, 20, 8'h41, 0, 0);
        send_item(MODE_LOAD, 1, 0, 0, 12'hFFF, 12'hFFF, 8'hFF, 0, 0);
        send_item(MODE_LOAD, 31, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'h00, 0, 0);
        drain();
        apb_write(3'd0, 32'd2);
        send_item(MODE_GAZE, 0, 100, 200, 0, 0, 0, 16'hFFFF, 0);
        send_item(MODE_GAZE, 0, 110, 220, 0, 0, 0, 16'h0001, 0);
        send_item(MODE_GAZE, 0, 111, 220, 0, 0, 0, 16'h0000, 0);
        send_item(MODE_GAZE, 0, 12'hFFF, 12'hFFF, 0, 0, 0, 16'hFFFF, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(MODE_READ, 1, 0, 0, 0, 0, 0, 0, 0);
        send_item(MODE_READ, 2, 0, 0, 0, 0, 0, 0, 0);
        drain();
        apb_write(3'd0, 32'd63);
        load_all(0);
        send_item(MODE_GAZE, 0, 12'hFFF, 12'hFFF, 0, 0, 0, 16'hFFFF, 0);
        send_item(MODE_READ, 31, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // receiver holds off while items keep coming
        hold_off = 400;
        for (int i = 0; i < 6; i++)
            send_item(MODE_READ, 5'(i), 0, 0, 0, 0, 0, 0, 1);
        drain();

        settings[0] = 6'd0; settings[1] = 6'd1; settings[2] = 6'd32;
        settings[3] = 6'd17; settings[4] = 6'd33;
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            apb_write(3'd0, {26'd0, settings[ph]});
            load_all(1);
            for (int i = 0; i < 290; i++)
                random_item();
        end
        drain();
        // dwell accumulation on one region under maximum durations
        apb_write(3'd0, 32'd1);
        send_item(MODE_LOAD, 0, 0, 0, 12'hFFF, 12'hFFF, 8'h5A, 0, 0);
        for (int i = 0; i < 60; i++)
            send_item(MODE_GAZE, 0, 12'($urandom), 12'($urandom), 0, 0, 0, 16'hFFFF, 1);
        drain();
        $display("ran %0d input beats, %0d results checked, region_count swept 0..63",
                 gaze_beats, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("gaze_region_statistics_tb passed");
        else
            $display("gaze_region_statistics_tb failed");
        $finish;
    end
endmodule
